/* rtl/core/lcd_bar_graph_update_core_assert.svh */
// Assertion macros shared by the bar graph update core.
// Needs a clock named clk and an active-low synchronous reset named rst_n in scope.
`ifndef LCD_BAR_GRAPH_UPDATE_CORE_ASSERT_SVH
`define LCD_BAR_GRAPH_UPDATE_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define LBG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define LBG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lbg_pkg.sv */
// Shared constants, types and helper functions of the bar graph update core.
// No dependencies; every other file of the core but the assertion header refers to this package.
package lbg_pkg;

  localparam int MAX_CELLS   = 20;
  localparam int CELL_PIXELS = 5;

  localparam int SAMPLE_W   = 16;
  localparam int CELL_W     = 5;
  localparam int COL_W      = 6;
  localparam int ROW_W      = 2;
  localparam int OUT_COL_W  = 7;
  localparam int GLYPH_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int PIX_W  = $clog2(MAX_CELLS * CELL_PIXELS + 1);
  localparam int NUM_W  = SAMPLE_W + PIX_W;
  localparam int STEP_W = (PIX_W > 1) ? $clog2(PIX_W) : 1;

  // Division by five as a multiply by 205/1024, exact for values below 1024.
  localparam int DIV5_MUL    = 205;
  localparam int DIV5_SHIFT  = 10;
  localparam int DIV5_PROD_W = DIV5_SHIFT + CELL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_START_COLUMN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_CELLS    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE    = CFG_IDX_W'(4);

  localparam logic [CELL_W-1:0]   BAR_CELLS_RESET = CELL_W'(16);
  localparam logic [SAMPLE_W-1:0] MAX_VALUE_RESET = SAMPLE_W'(1023);

  localparam logic [GLYPH_W-1:0] GLYPH_BLANK = GLYPH_W'(0);
  localparam logic [GLYPH_W-1:0] GLYPH_FULL  = GLYPH_W'(5);

  typedef enum logic [2:0] {
    EK_INIT_CURSOR,
    EK_UPD_CURSOR,
    EK_BLANK,
    EK_FULL,
    EK_PART
  } emit_kind_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_LOAD_SF,
    CNT_LOAD_USED,
    CNT_INC
  } cnt_op_t;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       mul;
    logic       div_step;
    logic       fin;
    logic       split;
    logic       emit;
    emit_kind_t kind;
    logic       last;
    cnt_op_t    cnt_op;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
    logic row_cleared;
    logic changed;
    logic cells_zero;
    logic full_gt;
    logic part_nz;
    logic blank_any;
    logic cnt_last_cells;
    logic cnt_last_full;
    logic cnt_last_end;
  } sts_t;

  function automatic logic [CELL_W-1:0] div5(input logic [PIX_W-1:0] pix);
    logic [DIV5_PROD_W-1:0] prod;
    prod = DIV5_PROD_W'(pix) * DIV5_PROD_W'(DIV5_MUL);
    return prod[DIV5_SHIFT +: CELL_W];
  endfunction

endpackage

/* rtl/core/lbg_if.sv */
// Valid/ready channel interfaces of the bar graph update core.
// Depends on lbg_pkg for the field widths.
interface lbg_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [lbg_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lbg_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           is_cursor;
  logic [lbg_pkg::OUT_COL_W-1:0]  cursor_column;
  logic [lbg_pkg::ROW_W-1:0]      cursor_row;
  logic [lbg_pkg::GLYPH_W-1:0]    glyph_code;
  logic                           last_command;

  modport source (output valid, output is_cursor, output cursor_column, output cursor_row,
                  output glyph_code, output last_command, input ready);
  modport sink   (input valid, input is_cursor, input cursor_column, input cursor_row,
                  input glyph_code, input last_command, output ready);
endinterface

/* rtl/core/lbg_datapath.sv */
// Datapath: configuration registers, scaling and division, bar state and output register.
// Depends on lbg_pkg; driven by lbg_ctrl through cmd_t and reporting through sts_t.
module lbg_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we_i,
  input  logic [lbg_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lbg_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic signed [lbg_pkg::SAMPLE_W-1:0]  in_sample_i,
  input  lbg_pkg::cmd_t                        cmd_i,
  output lbg_pkg::sts_t                        sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 out_is_cursor_o,
  output logic [lbg_pkg::OUT_COL_W-1:0]        out_cursor_column_o,
  output logic [lbg_pkg::ROW_W-1:0]            out_cursor_row_o,
  output logic [lbg_pkg::GLYPH_W-1:0]          out_glyph_code_o,
  output logic                                 out_last_command_o
);

  localparam int SW = lbg_pkg::SAMPLE_W;
  localparam int CW = lbg_pkg::CELL_W;
  localparam int PW = lbg_pkg::PIX_W;
  localparam int NW = lbg_pkg::NUM_W;
  localparam int TW = lbg_pkg::STEP_W;
  localparam int GW = lbg_pkg::GLYPH_W;
  localparam int OW = lbg_pkg::OUT_COL_W;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_DIV
  } mode_t;

  // Configuration
  logic [lbg_pkg::COL_W-1:0] start_column_r;
  logic [lbg_pkg::ROW_W-1:0] start_row_r;
  logic [CW-1:0]             bar_cells_r;
  logic signed [SW-1:0]      min_value_r;
  logic signed [SW-1:0]      max_value_r;

  // Bar as currently shown
  logic [PW-1:0] shown_pixels_r;
  logic [CW-1:0] shown_full_r;
  logic [CW-1:0] shown_used_r;
  logic          row_cleared_r;

  // Per-sample working registers
  logic signed [SW-1:0] sample_r;
  mode_t                mode_r;
  logic [SW-1:0]        v_r;
  logic [SW-1:0]        div_r;
  logic [NW-1:0]        rem_r;
  logic [PW-1:0]        q_r;
  logic [TW-1:0]        step_r;
  logic [PW-1:0]        pixels_r;
  logic                 changed_r;
  logic [CW-1:0]        full_r;
  logic [GW-1:0]        part_r;
  logic [CW-1:0]        used_r;
  logic [CW-1:0]        end_r;
  logic [CW-1:0]        cnt_r;

  // Output register
  logic          out_valid_r;
  logic          out_is_cursor_r;
  logic [OW-1:0] out_col_r;
  logic [lbg_pkg::ROW_W-1:0] out_row_r;
  logic [GW-1:0] out_glyph_r;
  logic          out_last_r;

  logic          out_is_cursor_nxt;
  logic [OW-1:0] out_col_nxt;
  logic [lbg_pkg::ROW_W-1:0] out_row_nxt;
  logic [GW-1:0] out_glyph_nxt;

  logic [CW-1:0]        cells;
  logic [PW-1:0]        c5;
  logic signed [SW:0]   s_ext;
  logic signed [SW:0]   lo_ext;
  logic signed [SW:0]   hi_ext;
  logic signed [SW:0]   d_ext;
  logic signed [SW:0]   v_ext;
  mode_t                mode_nxt;
  logic [NW-1:0]        dsh;
  logic [PW-1:0]        pix_nxt;
  logic [CW-1:0]        full_nxt;
  logic [GW-1:0]        part_nxt;
  logic [CW-1:0]        col_off;
  logic                 out_free;

  assign cells = (bar_cells_r > CW'(lbg_pkg::MAX_CELLS)) ? CW'(lbg_pkg::MAX_CELLS) : bar_cells_r;
  assign c5    = PW'(cells * lbg_pkg::CELL_PIXELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_column_r <= '0;
      start_row_r    <= '0;
      bar_cells_r    <= lbg_pkg::BAR_CELLS_RESET;
      min_value_r    <= '0;
      max_value_r    <= lbg_pkg::MAX_VALUE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lbg_pkg::CFG_START_COLUMN: start_column_r <= cfg_wdata_i[lbg_pkg::COL_W-1:0];
        lbg_pkg::CFG_START_ROW:    start_row_r    <= cfg_wdata_i[lbg_pkg::ROW_W-1:0];
        lbg_pkg::CFG_BAR_CELLS:    bar_cells_r    <= cfg_wdata_i[CW-1:0];
        lbg_pkg::CFG_MIN_VALUE:    min_value_r    <= cfg_wdata_i[SW-1:0];
        lbg_pkg::CFG_MAX_VALUE:    max_value_r    <= cfg_wdata_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // Clamping decides the mode; only the in-range case needs the division.
  always_comb begin
    s_ext  = (SW+1)'(sample_r);
    lo_ext = (SW+1)'(min_value_r);
    hi_ext = (SW+1)'(max_value_r);
    d_ext  = hi_ext - lo_ext;
    v_ext  = s_ext - lo_ext;
    if (d_ext == '0) begin
      mode_nxt = MODE_ZERO;
    end else if (s_ext > hi_ext) begin
      mode_nxt = MODE_FULL;
    end else if (s_ext < lo_ext) begin
      mode_nxt = MODE_ZERO;
    end else begin
      mode_nxt = MODE_DIV;
    end
  end

  assign dsh = NW'(div_r) << step_r;

  always_comb begin
    case (mode_r)
      MODE_DIV:  pix_nxt = q_r;
      MODE_FULL: pix_nxt = c5;
      default:   pix_nxt = '0;
    endcase
  end

  assign full_nxt = lbg_pkg::div5(pixels_r);
  assign part_nxt = GW'(pixels_r - PW'(full_nxt * lbg_pkg::CELL_PIXELS));

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      sample_r <= in_sample_i;
    end
    if (cmd_i.prep) begin
      mode_r <= mode_nxt;
      v_r    <= v_ext[SW-1:0];
      div_r  <= d_ext[SW-1:0];
    end
    if (cmd_i.mul) begin
      rem_r  <= NW'(v_r) * NW'(c5);
      q_r    <= '0;
      step_r <= TW'(PW - 1);
    end
    // Restoring division, one quotient bit per cycle from the top.
    if (cmd_i.div_step) begin
      if (rem_r >= dsh) begin
        rem_r         <= rem_r - dsh;
        q_r[step_r]   <= 1'b1;
      end
      step_r <= step_r - TW'(1);
    end
    if (cmd_i.fin) begin
      pixels_r  <= pix_nxt;
      changed_r <= (pix_nxt != shown_pixels_r);
    end
    if (cmd_i.split) begin
      full_r <= full_nxt;
      part_r <= part_nxt;
      used_r <= full_nxt + CW'(part_nxt != '0);
      end_r  <= (shown_used_r > CW'(lbg_pkg::MAX_CELLS)) ? CW'(lbg_pkg::MAX_CELLS)
                                                         : shown_used_r;
    end
    case (cmd_i.cnt_op)
      lbg_pkg::CNT_CLR:       cnt_r <= '0;
      lbg_pkg::CNT_LOAD_SF:   cnt_r <= shown_full_r;
      lbg_pkg::CNT_LOAD_USED: cnt_r <= used_r;
      lbg_pkg::CNT_INC:       cnt_r <= cnt_r + CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_pixels_r <= '0;
      shown_full_r   <= '0;
      shown_used_r   <= '0;
      row_cleared_r  <= 1'b0;
    end else if (cmd_i.commit) begin
      row_cleared_r <= 1'b1;
      if (changed_r) begin
        shown_pixels_r <= pixels_r;
        shown_full_r   <= full_r;
        shown_used_r   <= used_r;
      end
    end
  end

  // The update cursor lands on the first cell that changes.
  assign col_off  = (full_r > shown_full_r) ? shown_full_r : full_r;
  assign out_free = !out_valid_r || out_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_is_cursor_nxt = 1'b0;
    out_col_nxt       = '0;
    out_row_nxt       = '0;
    out_glyph_nxt     = lbg_pkg::GLYPH_BLANK;
    case (cmd_i.kind)
      lbg_pkg::EK_INIT_CURSOR: begin
        out_is_cursor_nxt = 1'b1;
        out_col_nxt       = OW'(start_column_r);
        out_row_nxt       = start_row_r;
      end
      lbg_pkg::EK_UPD_CURSOR: begin
        out_is_cursor_nxt = 1'b1;
        out_col_nxt       = OW'(start_column_r) + OW'(col_off);
        out_row_nxt       = start_row_r;
      end
      lbg_pkg::EK_FULL: out_glyph_nxt = lbg_pkg::GLYPH_FULL;
      lbg_pkg::EK_PART: out_glyph_nxt = part_r;
      default:          out_glyph_nxt = lbg_pkg::GLYPH_BLANK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_last_r      <= cmd_i.last;
      out_is_cursor_r <= out_is_cursor_nxt;
      out_col_r       <= out_col_nxt;
      out_row_r       <= out_row_nxt;
      out_glyph_r     <= out_glyph_nxt;
    end
  end

  assign out_valid_o         = out_valid_r;
  assign out_is_cursor_o     = out_is_cursor_r;
  assign out_cursor_column_o = out_col_r;
  assign out_cursor_row_o    = out_row_r;
  assign out_glyph_code_o    = out_glyph_r;
  assign out_last_command_o  = out_last_r;

  always_comb begin
    sts_o.out_free       = out_free;
    sts_o.div_done       = (step_r == '0);
    sts_o.row_cleared    = row_cleared_r;
    sts_o.changed        = changed_r;
    sts_o.cells_zero     = (cells == '0);
    sts_o.full_gt        = (full_r > shown_full_r);
    sts_o.part_nz        = (part_r != '0);
    sts_o.blank_any      = (used_r < end_r);
    sts_o.cnt_last_cells = (cnt_r == CW'(cells - CW'(1)));
    sts_o.cnt_last_full  = (cnt_r == CW'(full_r - CW'(1)));
    sts_o.cnt_last_end   = (cnt_r == CW'(end_r - CW'(1)));
  end

endmodule

/* rtl/core/lbg_ctrl.sv */
// Controller: sequences scaling, division and the run of display commands for one sample.
// Depends on lbg_pkg and the assertion macros in lcd_bar_graph_update_core_assert.svh.
`include "lcd_bar_graph_update_core_assert.svh"

module lbg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lbg_pkg::sts_t sts_i,
  output lbg_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE       = 13'h0001,
    ST_PREP       = 13'h0002,
    ST_MUL        = 13'h0004,
    ST_DIV        = 13'h0008,
    ST_FIN        = 13'h0010,
    ST_SPLIT      = 13'h0020,
    ST_INIT_CUR   = 13'h0040,
    ST_INIT_BLANK = 13'h0080,
    ST_CUR        = 13'h0100,
    ST_FULL       = 13'h0200,
    ST_PART       = 13'h0400,
    ST_BLANK      = 13'h0800,
    ST_DONE       = 13'h1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_o         = '0;
    cmd_o.kind    = lbg_pkg::EK_BLANK;
    cmd_o.cnt_op  = lbg_pkg::CNT_HOLD;
    in_ready_o    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        if (!sts_i.row_cleared) begin
          state_nxt = ST_INIT_CUR;
        end else if (sts_i.changed) begin
          state_nxt = ST_CUR;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_INIT_CUR: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = lbg_pkg::EK_INIT_CURSOR;
          cmd_o.last   = sts_i.cells_zero && !sts_i.changed;
          cmd_o.cnt_op = lbg_pkg::CNT_CLR;
          if (!sts_i.cells_zero) begin
            state_nxt = ST_INIT_BLANK;
          end else if (sts_i.changed) begin
            state_nxt = ST_CUR;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_INIT_BLANK: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = lbg_pkg::EK_BLANK;
          cmd_o.last   = sts_i.cnt_last_cells && !sts_i.changed;
          cmd_o.cnt_op = lbg_pkg::CNT_INC;
          if (sts_i.cnt_last_cells) begin
            state_nxt = sts_i.changed ? ST_CUR : ST_DONE;
          end
        end
      end
      ST_CUR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = lbg_pkg::EK_UPD_CURSOR;
          cmd_o.last = !sts_i.full_gt && !sts_i.part_nz && !sts_i.blank_any;
          if (sts_i.full_gt) begin
            cmd_o.cnt_op = lbg_pkg::CNT_LOAD_SF;
            state_nxt    = ST_FULL;
          end else if (sts_i.part_nz) begin
            state_nxt = ST_PART;
          end else if (sts_i.blank_any) begin
            cmd_o.cnt_op = lbg_pkg::CNT_LOAD_USED;
            state_nxt    = ST_BLANK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = lbg_pkg::EK_FULL;
          cmd_o.last   = sts_i.cnt_last_full && !sts_i.part_nz && !sts_i.blank_any;
          cmd_o.cnt_op = lbg_pkg::CNT_INC;
          if (sts_i.cnt_last_full) begin
            if (sts_i.part_nz) begin
              state_nxt = ST_PART;
            end else if (sts_i.blank_any) begin
              cmd_o.cnt_op = lbg_pkg::CNT_LOAD_USED;
              state_nxt    = ST_BLANK;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_PART: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = lbg_pkg::EK_PART;
          cmd_o.last = !sts_i.blank_any;
          if (sts_i.blank_any) begin
            cmd_o.cnt_op = lbg_pkg::CNT_LOAD_USED;
            state_nxt    = ST_BLANK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_BLANK: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = lbg_pkg::EK_BLANK;
          cmd_o.last   = sts_i.cnt_last_end;
          cmd_o.cnt_op = lbg_pkg::CNT_INC;
          if (sts_i.cnt_last_end) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        cmd_o.commit = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `LBG_ASSERT_SAME(a_emit_needs_room, cmd_o.emit, sts_i.out_free, "command issued into a full output register")
  `LBG_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_r == ST_PREP, "accepted sample did not start processing")
  `LBG_ASSERT_NEXT(a_last_ends_run, cmd_o.emit && cmd_o.last, state_r == ST_DONE, "final command not followed by state update")

endmodule

/* rtl/core/lcd_bar_graph_update_core.sv */
// Character display bar graph updater: turns each sample into a run of cursor and glyph commands.
// Channels use lbg_sample_if and lbg_cmd_if; controller lbg_ctrl drives datapath lbg_datapath.
//
// Usage:
//   in_if carries one signed 16-bit sample per transaction; out_if carries one display
//   command per transaction, with last_command set on the final command of a sample.
//   cfg_we/cfg_index/cfg_wdata write the five settings (start column, start row, cell count,
//   minimum, maximum); writes are to be made by the user while no sample is in progress,
//   as the core itself does not enforce this. A sample is accepted only when the core is idle.
//   Scaling (clamp, a 16x7 multiply and a 7-step restoring division, one quotient bit per
//   cycle) comes before the first command reaches the output register; the commands follow,
//   each waiting while the output register is full, and a final state updates the stored bar.
//   A sample yields 0 to 42 commands. The output register holds one command; while the
//   receiver stalls the core waits with the next command, and the last command of a sample
//   may still be waiting while the next sample is taken in.
//   After reset the settings take their default values, the stored bar is empty and the
//   first sample is preceded by a cursor set and a blank row over the whole bar.
module lcd_bar_graph_update_core (
  input  logic                            clk,
  input  logic                            rst_n,
  lbg_sample_if.sink                      in_if,
  lbg_cmd_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [lbg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  lbg_pkg::cmd_t cmd;
  lbg_pkg::sts_t sts;
  logic          in_ready;

  assign in_if.ready = in_ready;

  lbg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbg_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata),
    .in_sample_i         (in_if.sample),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_if.valid),
    .out_ready_i         (out_if.ready),
    .out_is_cursor_o     (out_if.is_cursor),
    .out_cursor_column_o (out_if.cursor_column),
    .out_cursor_row_o    (out_if.cursor_row),
    .out_glyph_code_o    (out_if.glyph_code),
    .out_last_command_o  (out_if.last_command)
  );

endmodule
